@@ rtl/scalar_kalman_filter_macros.svh @@
// Assertion macros for the scalar Kalman filter RTL.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, off during reset.
`define SKF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SKF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/skf_pkg.sv @@
// Package for the scalar Kalman filter: widths, register indexes, reset values,
// sequencer states and the configuration bundle. No dependencies.
`timescale 1ns / 1ps
package skf_pkg;

  localparam int COV_WIDTH          = 24;
  localparam int CFG_IDX_W          = 8;
  localparam int DEF_SAMPLE_WIDTH   = 24;
  localparam int DEF_GAIN_FRAC_BITS = 16;

  localparam logic [COV_WIDTH-1:0] RST_PROCESS_NOISE      = 24'd6554;
  localparam logic [COV_WIDTH-1:0] RST_MEASUREMENT_NOISE  = 24'd196608;
  localparam logic [COV_WIDTH-1:0] RST_INITIAL_COVARIANCE = 24'd65536;
  localparam logic [COV_WIDTH-1:0] RST_COVARIANCE         = 24'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE      = 8'd0,
    REG_MEASUREMENT_NOISE  = 8'd1,
    REG_INITIAL_ESTIMATE   = 8'd2,
    REG_INITIAL_COVARIANCE = 8'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DENOM,
    ST_DIV,
    ST_ROUND,
    ST_WB
  } state_e;

  typedef struct packed {
    logic [COV_WIDTH-1:0] process_noise;
    logic [COV_WIDTH-1:0] measurement_noise;
    logic [COV_WIDTH-1:0] initial_covariance;
  } cov_cfg_t;

endpackage

@@ rtl/skf_in_if.sv @@
// Sample channel of the scalar Kalman filter: valid/ready plus sample and restart payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface skf_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] measurement;
  logic                           restart;

  modport source (output valid, measurement, restart, input ready);
  modport sink   (input valid, measurement, restart, output ready);
endinterface

@@ rtl/skf_out_if.sv @@
// Result channel of the scalar Kalman filter: valid/ready plus estimate, gain
// and covariance payload. Depends on nothing.
`timescale 1ns / 1ps
interface skf_out_if #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int GAIN_FRAC_BITS = 16,
  parameter int COV_WIDTH      = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered_value;
  logic [GAIN_FRAC_BITS:0]        gain;
  logic [COV_WIDTH-1:0]           error_covariance;

  modport source (output valid, filtered_value, gain, error_covariance, input ready);
  modport sink   (input valid, filtered_value, gain, error_covariance, output ready);
endinterface

@@ rtl/skf_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on nothing.
`timescale 1ns / 1ps
interface skf_cfg_if #(
  parameter int IDX_WIDTH  = 8,
  parameter int DATA_WIDTH = 24
);
  logic                  valid;
  logic                  ready;
  logic [IDX_WIDTH-1:0]  index;
  logic [DATA_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/skf_cfg_regs.sv @@
// Configuration register file of the scalar Kalman filter.
// Depends on skf_pkg and skf_cfg_if.
`timescale 1ns / 1ps
module skf_cfg_regs
  import skf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  skf_cfg_if.sink                        cfg_i,
  output cov_cfg_t                       cov_cfg_o,
  output logic signed [SAMPLE_WIDTH-1:0] init_est_o
);

  cov_cfg_t                       cov_cfg_q;
  logic signed [SAMPLE_WIDTH-1:0] init_est_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_cfg_q.process_noise      <= RST_PROCESS_NOISE;
      cov_cfg_q.measurement_noise  <= RST_MEASUREMENT_NOISE;
      cov_cfg_q.initial_covariance <= RST_INITIAL_COVARIANCE;
      init_est_q                   <= '0;
    end else if (cfg_i.valid) begin
      // unknown indexes are dropped
      case (cfg_i.index)
        REG_PROCESS_NOISE:      cov_cfg_q.process_noise      <= cfg_i.data[COV_WIDTH-1:0];
        REG_MEASUREMENT_NOISE:  cov_cfg_q.measurement_noise  <= cfg_i.data[COV_WIDTH-1:0];
        REG_INITIAL_ESTIMATE:   init_est_q                   <= cfg_i.data[SAMPLE_WIDTH-1:0];
        REG_INITIAL_COVARIANCE: cov_cfg_q.initial_covariance <= cfg_i.data[COV_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign cov_cfg_o  = cov_cfg_q;
  assign init_est_o = init_est_q;

endmodule

@@ rtl/skf_step.sv @@
// One iteration of the shared divide/multiply unit: a restoring-division step
// for the gain, whose quotient bit drives two MSB-first shift-add accumulators.
// Depends on skf_pkg.
`timescale 1ns / 1ps
module skf_step
  import skf_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
  localparam int AW_MAG = SAMPLE_WIDTH + GAIN_FRAC_BITS + 1,
  localparam int AW_COV = COV_WIDTH + GAIN_FRAC_BITS + 1
) (
  input  logic [COV_WIDTH+1:0]    rem_i,
  input  logic [COV_WIDTH:0]      denom_i,
  input  logic                    denom_nz_i,
  input  logic [SAMPLE_WIDTH-1:0] mag_i,
  input  logic [COV_WIDTH-1:0]    pp_i,
  input  logic [AW_MAG-1:0]       acc_mag_i,
  input  logic [AW_COV-1:0]       acc_cov_i,
  input  logic [GAIN_FRAC_BITS:0] quot_i,
  output logic [COV_WIDTH+1:0]    rem_o,
  output logic [AW_MAG-1:0]       acc_mag_o,
  output logic [AW_COV-1:0]       acc_cov_o,
  output logic [GAIN_FRAC_BITS:0] quot_o
);

  logic                   qbit;
  logic [COV_WIDTH+1:0]   rem_sub;

  // a zero denominator forces every quotient bit low, so the gain is zero
  assign qbit    = denom_nz_i && (rem_i >= {1'b0, denom_i});
  assign rem_sub = qbit ? (rem_i - {1'b0, denom_i}) : rem_i;
  assign rem_o   = {rem_sub[COV_WIDTH:0], 1'b0};

  assign acc_mag_o = {acc_mag_i[AW_MAG-2:0], 1'b0} + (qbit ? AW_MAG'(mag_i) : '0);
  assign acc_cov_o = {acc_cov_i[AW_COV-2:0], 1'b0} + (qbit ? AW_COV'(pp_i) : '0);
  assign quot_o    = {quot_i[GAIN_FRAC_BITS-1:0], qbit};

endmodule

@@ rtl/scalar_kalman_filter.sv @@
// A sample is taken only in IDLE and passes through LOAD, DENOM, DIV, ROUND and WB
// before the next one is accepted; DIV makes GAIN_FRAC_BITS+1 passes through the
// shared divide/multiply step unit.
// The result register lets the next sample start while a result waits.
// Reset: estimate 0, covariance one (65536), registers to their defaults, no result.
`timescale 1ns / 1ps
`include "scalar_kalman_filter_macros.svh"
module scalar_kalman_filter
  import skf_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skf_in_if.sink    meas_i,
  skf_out_if.source res_o,
  skf_cfg_if.sink   cfg_i
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int F      = GAIN_FRAC_BITS;
  localparam int AW_MAG = SW + F + 1;
  localparam int AW_COV = COV_WIDTH + F + 1;
  localparam int CNT_W  = $clog2(F + 1);
  localparam logic [AW_MAG-1:0] HALF_MAG = AW_MAG'(1) << (F - 1);
  localparam logic [AW_COV-1:0] HALF_COV = AW_COV'(1) << (F - 1);
  localparam logic [F:0]        GAIN_ONE = (F + 1)'(1) << F;

  cov_cfg_t                 cov_cfg;
  logic signed [SW-1:0]     init_est;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [SW-1:0]     z_q;
  logic                     restart_q;
  logic signed [SW-1:0]     x_q;
  logic [COV_WIDTH-1:0]     p_q;
  logic [COV_WIDTH-1:0]     pp_q;
  logic [COV_WIDTH:0]       denom_q;
  logic [COV_WIDTH+1:0]     rem_q;
  logic [AW_MAG-1:0]        acc_mag_q;
  logic [AW_COV-1:0]        acc_cov_q;
  logic [F:0]               k_q;
  logic [SW-1:0]            mag_q;
  logic                     neg_q;
  logic [SW-1:0]            delta_q;

  logic                     out_valid_q;
  logic signed [SW-1:0]     out_x_q;
  logic [F:0]               out_k_q;
  logic [COV_WIDTH-1:0]     out_p_q;

  logic                     in_ready;
  logic                     in_fire;
  logic                     wb_fire;

  logic signed [SW-1:0]     x_sel;
  logic [COV_WIDTH-1:0]     p_sel;
  logic [SW:0]              diff;
  logic [SW:0]              diff_abs;
  logic [COV_WIDTH:0]       pp_sum;
  logic [COV_WIDTH-1:0]     pp_sat;
  logic [AW_MAG-1:0]        delta_sum;
  logic [AW_COV-1:0]        cov_sum;
  logic signed [SW-1:0]     x_new;

  logic [COV_WIDTH+1:0]     rem_nxt;
  logic [AW_MAG-1:0]        acc_mag_nxt;
  logic [AW_COV-1:0]        acc_cov_nxt;
  logic [F:0]               k_nxt;

  skf_cfg_regs #(
    .SAMPLE_WIDTH(SW)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .cov_cfg_o (cov_cfg),
    .init_est_o(init_est)
  );

  skf_step #(
    .SAMPLE_WIDTH  (SW),
    .GAIN_FRAC_BITS(F)
  ) u_step (
    .rem_i     (rem_q),
    .denom_i   (denom_q),
    .denom_nz_i(denom_q != '0),
    .mag_i     (mag_q),
    .pp_i      (pp_q),
    .acc_mag_i (acc_mag_q),
    .acc_cov_i (acc_cov_q),
    .quot_i    (k_q),
    .rem_o     (rem_nxt),
    .acc_mag_o (acc_mag_nxt),
    .acc_cov_o (acc_cov_nxt),
    .quot_o    (k_nxt)
  );

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (meas_i.valid) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DENOM;
      ST_DENOM: state_d = ST_DIV;
      ST_DIV:   if (cnt_q == '0) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_WB;
      ST_WB:    if (!out_valid_q || res_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    wb_fire  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_WB:   wb_fire  = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  assign meas_i.ready = in_ready;
  assign in_fire      = meas_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- datapath ----
  assign x_sel    = restart_q ? init_est : x_q;
  assign p_sel    = restart_q ? cov_cfg.initial_covariance : p_q;
  assign diff     = {z_q[SW-1], z_q} - {x_sel[SW-1], x_sel};
  assign diff_abs = diff[SW] ? (~diff + 1'b1) : diff;
  assign pp_sum   = {1'b0, p_sel} + {1'b0, cov_cfg.process_noise};
  assign pp_sat   = pp_sum[COV_WIDTH] ? '1 : pp_sum[COV_WIDTH-1:0];

  // delta = round(K*|z-x|), P = round((1-K)*Pp) = round((Pp*2^F - K*2^F*Pp) / 2^F)
  assign delta_sum = acc_mag_q + HALF_MAG;
  assign cov_sum   = {1'b0, pp_q, {F{1'b0}}} - acc_cov_q + HALF_COV;
  assign x_new     = neg_q ? (x_q - delta_q) : (x_q + delta_q);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      z_q       <= meas_i.measurement;
      restart_q <= meas_i.restart;
    end
    case (state_q)
      ST_LOAD: begin
        pp_q  <= pp_sat;
        mag_q <= diff_abs[SW-1:0];
        neg_q <= diff[SW];
      end
      ST_DENOM: begin
        denom_q   <= {1'b0, pp_q} + {1'b0, cov_cfg.measurement_noise};
        rem_q     <= {2'b00, pp_q};
        acc_mag_q <= '0;
        acc_cov_q <= '0;
        k_q       <= '0;
        cnt_q     <= CNT_W'(F);
      end
      ST_DIV: begin
        rem_q     <= rem_nxt;
        acc_mag_q <= acc_mag_nxt;
        acc_cov_q <= acc_cov_nxt;
        k_q       <= k_nxt;
        cnt_q     <= cnt_q - 1'b1;
      end
      ST_ROUND: delta_q <= delta_sum[F+SW-1:F];
      default: ;
    endcase
    if (wb_fire) begin
      out_x_q <= x_new;
      out_k_q <= k_q;
      out_p_q <= p_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      p_q         <= RST_COVARIANCE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_LOAD) x_q <= x_sel;
      else if (wb_fire)       x_q <= x_new;
      if (state_q == ST_ROUND) p_q <= cov_sum[F+COV_WIDTH-1:F];
      if (wb_fire)             out_valid_q <= 1'b1;
      else if (res_o.ready)    out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.filtered_value   = out_x_q;
  assign res_o.gain             = out_k_q;
  assign res_o.error_covariance = out_p_q;

  // ---- checks ----
  `SKF_ASSERT_IMP(a_gain_le_one, out_valid_q, out_k_q <= GAIN_ONE, "gain above one")
  `SKF_ASSERT_NXT(a_cov_shrinks, state_q == ST_ROUND, p_q <= pp_q, "covariance above Pp")
  `SKF_ASSERT_NXT(a_zero_denom_gain, state_q == ST_DIV && denom_q == '0, k_q == '0,
                  "nonzero gain with zero denominator")
  `SKF_ASSERT_NXT(a_wb_holds, state_q == ST_WB && out_valid_q && !res_o.ready,
                  state_q == ST_WB, "result overwritten while pending")

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for scalar_kalman_filter: directed table, then random phases.
// Results are checked against an in-bench fixed-point predictor, or against the table's values for typed rows.
// Depends on skf_pkg, scalar_kalman_filter and the skf_in_if, skf_out_if and skf_cfg_if interfaces.
`timescale 1ns / 1ps
module tb;
  import skf_pkg::*;

  localparam int SW = DEF_SAMPLE_WIDTH;
  localparam int GF = DEF_GAIN_FRAC_BITS;

  localparam logic [SW-1:0]        SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0]        SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [COV_WIDTH-1:0] COV_MAX    = '1;
  localparam logic [63:0]          GAIN_ONE   = 64'd1 << GF;
  localparam logic [63:0]          GAIN_HALF  = 64'd1 << (GF - 1);

  // first and last register index that decode to nothing
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 8'd255;

  localparam int SETTLE_CYCLES   = 30;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int TIMEOUT_NS      = 2_000_000;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PREDICT,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    logic signed [SW-1:0]  value;
    logic [GF:0]           gain;
    logic [COV_WIDTH-1:0]  cov;
  } filt_result_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [SW-1:0]         data;
    logic                  restart;
    logic [SW-1:0]         exp_value;
    logic [GF:0]           exp_gain;
    logic [COV_WIDTH-1:0]  exp_cov;
  } dir_row_t;

  localparam int NUM_DIR_ROWS = 33;

  // data is the register value for writes and the sample for the others
  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    // defaults after reset
    '{ROW_PREDICT, 8'd0, 24'h000000, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_PREDICT, 8'd0, 24'h7FFFFF, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_PREDICT, 8'd0, 24'h800000, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_PREDICT, 8'd0, 24'h000100, 1'b1, 24'h0, 17'd0, 24'd0},
    // no noise at all: unity gain, then a zero denominator, then unity gain after a restart
    '{ROW_WRITE, REG_PROCESS_NOISE,     24'h000000, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, REG_MEASUREMENT_NOISE, 24'h000000, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_TYPED, 8'd0, 24'h7FFFFF, 1'b0, 24'h7FFFFF, 17'd65536, 24'd0},
    '{ROW_TYPED, 8'd0, 24'h800000, 1'b0, 24'h7FFFFF, 17'd0, 24'd0},
    '{ROW_TYPED, 8'd0, 24'h800000, 1'b1, 24'h800000, 17'd65536, 24'd0},
    // restart into a zero covariance at the most negative estimate
    '{ROW_WRITE, REG_INITIAL_ESTIMATE,   24'h800000, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, REG_INITIAL_COVARIANCE, 24'h000000, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_TYPED, 8'd0, 24'h7FFFFF, 1'b1, 24'h800000, 17'd0, 24'd0},
    // P+Q saturates; with R at max too the gain is exactly one half
    '{ROW_WRITE, REG_PROCESS_NOISE,      24'hFFFFFF, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, REG_MEASUREMENT_NOISE,  24'hFFFFFF, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, REG_INITIAL_ESTIMATE,   24'h000000, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, REG_INITIAL_COVARIANCE, 24'hFFFFFF, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_TYPED, 8'd0, 24'h000002, 1'b1, 24'h000001, 17'd32768, 24'd8388608},
    '{ROW_TYPED, 8'd0, 24'h800000, 1'b0, 24'hC00000, 17'd32768, 24'd8388608},
    '{ROW_PREDICT, 8'd0, 24'h7FFFFF, 1'b0, 24'h0, 17'd0, 24'd0},
    // writes to undecoded indexes must not land anywhere
    '{ROW_WRITE, IDX_UNUSED_LO, 24'hFFFFFF, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, IDX_UNUSED_HI, 24'h000000, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, REG_PROCESS_NOISE,     24'h000001, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, REG_MEASUREMENT_NOISE, 24'hFFFFFF, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_PREDICT, 8'd0, 24'h000001, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_PREDICT, 8'd0, 24'hFFFFFF, 1'b1, 24'h0, 17'd0, 24'd0},
    // back near the defaults with a nonzero restart estimate
    '{ROW_WRITE, REG_PROCESS_NOISE,      24'd6554,   1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, REG_MEASUREMENT_NOISE,  24'd196608, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, REG_INITIAL_ESTIMATE,   24'd1000,   1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_WRITE, REG_INITIAL_COVARIANCE, 24'd65536,  1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_PREDICT, 8'd0, 24'd5000,   1'b1, 24'h0, 17'd0, 24'd0},
    '{ROW_PREDICT, 8'd0, 24'hFFEC78, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_PREDICT, 8'd0, 24'hAAAAAA, 1'b0, 24'h0, 17'd0, 24'd0},
    '{ROW_PREDICT, 8'd0, 24'h555555, 1'b0, 24'h0, 17'd0, 24'd0}
  };

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic res_ready = 1'b0;

  int idle_odds  = 0;  // 0: no idling, else each chance to idle starts a burst with odds of 1 in idle_odds+1
  int stall_left = 0;
  int mismatches = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int cfg_writes   = 0;

  // predictor state and register copies
  logic [COV_WIDTH-1:0] q_noise;
  logic [COV_WIDTH-1:0] r_noise;
  logic [SW-1:0]        x_init;
  logic [COV_WIDTH-1:0] p_init;
  logic signed [SW-1:0] est_q;
  logic [COV_WIDTH-1:0] cov_q;

  filt_result_t pending_results [$];

  skf_in_if  #(.SAMPLE_WIDTH(SW)) meas_if ();
  skf_out_if #(.SAMPLE_WIDTH(SW), .GAIN_FRAC_BITS(GF), .COV_WIDTH(COV_WIDTH)) res_if ();
  skf_cfg_if #(.IDX_WIDTH(CFG_IDX_W), .DATA_WIDTH(COV_WIDTH)) cfg_if ();

  assign res_if.ready = res_ready;

  scalar_kalman_filter #(
    .SAMPLE_WIDTH  (SW),
    .GAIN_FRAC_BITS(GF)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .meas_i(meas_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    res_ready <= (stall_left == 0);
  end

  function automatic filt_result_t predict_update(input logic signed [SW-1:0] z,
                                                  input logic rs);
    logic [63:0]  pp, denom, k, mag, delta;
    longint       diff, next_x;
    filt_result_t res;
    if (rs) begin
      est_q = x_init;
      cov_q = p_init;
    end
    pp = 64'(cov_q) + 64'(q_noise);
    if (pp > 64'(COV_MAX)) pp = 64'(COV_MAX);
    denom = pp + 64'(r_noise);
    k = (denom == 64'd0) ? 64'd0 : (pp << GF) / denom;
    diff = longint'(z) - longint'(est_q);
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    // rounds the step magnitude half away from zero
    delta = (k * mag + GAIN_HALF) >> GF;
    next_x = (diff < 0) ? longint'(est_q) - longint'(delta) : longint'(est_q) + longint'(delta);
    est_q = SW'(next_x);
    cov_q = COV_WIDTH'(((GAIN_ONE - k) * pp + GAIN_HALF) >> GF);
    res.value = est_q;
    res.gain  = k[GF:0];
    res.cov   = cov_q;
    return res;
  endfunction

  function automatic logic [COV_WIDTH-1:0] pick_reg_value();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return COV_MAX;
      2: return COV_WIDTH'(SAMPLE_MIN);
      3: return COV_WIDTH'($urandom_range(0, 255));
      4: return COV_WIDTH'($urandom_range(0, 24'h3FFFF));
      default: return COV_WIDTH'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             field, results_seen, got, want);
    mismatches++;
  endtask

  task automatic send_sample(input logic [SW-1:0] z, input logic rs, input logic typed,
                             input filt_result_t want);
    filt_result_t pred;
    if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      meas_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    meas_if.valid       <= 1'b1;
    meas_if.measurement <= z;
    meas_if.restart     <= rs;
    @(posedge clk_i);
    while (!meas_if.ready) @(posedge clk_i);
    pred = predict_update($signed(z), rs);
    pending_results.push_back(typed ? want : pred);
    samples_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COV_WIDTH-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_PROCESS_NOISE:      q_noise = data;
      REG_MEASUREMENT_NOISE:  r_noise = data;
      REG_INITIAL_ESTIMATE:   x_init  = data[SW-1:0];
      REG_INITIAL_COVARIANCE: p_init  = data;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // stop feeding samples and let every outstanding result come back
  task automatic wait_results_idle();
    meas_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    filt_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, filtered_value", longint'(res_if.filtered_value), 0);
      end else begin
        want = pending_results.pop_front();
        if (res_if.filtered_value !== want.value)
          report_mismatch("filtered_value", longint'(res_if.filtered_value), longint'(want.value));
        if (res_if.gain !== want.gain)
          report_mismatch("gain", longint'(res_if.gain), longint'(want.gain));
        if (res_if.error_covariance !== want.cov)
          report_mismatch("error_covariance", longint'(res_if.error_covariance),
                          longint'(want.cov));
      end
    end
  end

  initial begin : stimulus
    filt_result_t  want;
    filt_result_t  no_want;
    logic [SW-1:0] z;
    logic [SW-1:0] level;
    logic          rs;

    no_want = '0;
    meas_if.valid       <= 1'b0;
    meas_if.measurement <= '0;
    meas_if.restart     <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    rst_ni              <= 1'b0;

    q_noise = RST_PROCESS_NOISE;
    r_noise = RST_MEASUREMENT_NOISE;
    x_init  = '0;
    p_init  = RST_INITIAL_COVARIANCE;
    est_q   = '0;
    cov_q   = RST_COVARIANCE;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_odds = 3;
    for (int i = 0; i < NUM_DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        wait_results_idle();
        cfg_write(dir_rows[i].index, dir_rows[i].data);
      end else begin
        want.value = dir_rows[i].exp_value;
        want.gain  = dir_rows[i].exp_gain;
        want.cov   = dir_rows[i].exp_cov;
        send_sample(dir_rows[i].data, dir_rows[i].restart, dir_rows[i].kind == ROW_TYPED, want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_results_idle();
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 2;
        default: idle_odds = 6;
      endcase
      if (ph == NUM_PHASES - 1) idle_odds = 0;
      cfg_write(REG_PROCESS_NOISE, pick_reg_value());
      cfg_write(REG_MEASUREMENT_NOISE, pick_reg_value());
      cfg_write(REG_INITIAL_ESTIMATE, pick_reg_value());
      cfg_write(REG_INITIAL_COVARIANCE, pick_reg_value());
      if ($urandom_range(0, 2) == 0)
        cfg_write(CFG_IDX_W'($urandom_range(IDX_UNUSED_LO, IDX_UNUSED_HI)), COV_WIDTH'($urandom));
      level = SW'($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0: z = SW'($urandom);
          1: z = SAMPLE_MAX;
          2: z = SAMPLE_MIN;
          3: z = SW'($urandom_range(0, 510) - 255);
          default: begin
            // slowly drifting signal plus noise, the way the filter is meant to be used
            level = level + SW'($urandom_range(0, 2048) - 1024);
            z = level + SW'($urandom_range(0, 8192) - 4096);
          end
        endcase
        rs = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0);
        send_sample(z, rs, 1'b0, no_want);
      end
    end

    wait_results_idle();
    $display("covered %0d samples over %0d table rows and %0d random phases, %0d register writes",
             samples_sent, NUM_DIR_ROWS, NUM_PHASES, cfg_writes);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/skf_pkg.sv
rtl/skf_in_if.sv
rtl/skf_out_if.sv
rtl/skf_cfg_if.sv
rtl/skf_cfg_regs.sv
rtl/skf_step.sv
rtl/scalar_kalman_filter.sv
tb/sv/tb.sv
